### src/smavg_pkg.sv
package smavg_pkg;

  localparam int unsigned Axes    = 6;
  localparam int unsigned SampleW = 16;
  localparam int unsigned DataW   = Axes * SampleW;

  typedef logic [SampleW-1:0] sample_t;
  typedef sample_t [Axes-1:0] axes_t;

endpackage

### src/six_axis_moving_average_top.sv
// Path: each sum passes the two-entry queue, then the magnitude, product and output registers.
// Throughput: one sample per cycle while the output is not stalled; the running sums
// and the reciprocal multiply pipeline each take one sample a cycle while not stalled.
// Reset clears every window and running sum to zero, so early means include zeros.
// A two-entry queue parts the sum stage from the divide pipeline.
module six_axis_moving_average_top import smavg_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z; 16 bits each, lowest first
  input  logic [DataW-1:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // mean_accel_x, mean_accel_y, mean_accel_z, mean_rate_x, mean_rate_y,
  // mean_rate_z; 16 bits each, lowest first
  output logic [DataW-1:0] m_axis_tdata_o
);

  // Sum width: a window of WINDOW_LEN signed 16-bit samples.
  localparam int unsigned SumW = SampleW + $clog2(WINDOW_LEN);

  axes_t                     sample;
  axes_t                     mean;
  logic [Axes-1:0][SumW-1:0] front_sum, q_sum;
  logic                      push, q_ready, q_valid, pop;

  // Unpack the stream word into axes, first axis in the lowest bits.
  assign sample = s_axis_tdata_i;

  // Front: hold each window and advance its running sum on every transfer.
  smavg_front #(
    .WINDOW_LEN (WINDOW_LEN),
    .SumW       (SumW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .sample_i  (sample),
    .q_ready_i (q_ready),
    .push_o    (push),
    .sum_o     (front_sum)
  );

  // Queue: decouple the sums from the divide pipeline so each side stalls alone.
  smavg_queue #(
    .Width (Axes * SumW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .data_i  (front_sum),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_sum)
  );

  // Back: divide each sum by the window length, rounding toward zero,
  // through sign/magnitude, reciprocal multiply and an output register.
  smavg_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .SumW       (SumW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .pop_o   (pop),
    .sum_i   (q_sum),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .mean_o  (mean)
  );

  assign m_axis_tdata_o = mean;

endmodule

### src/smavg_front.sv
module smavg_front import smavg_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 10,
  parameter int unsigned SumW       = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  axes_t                          sample_i,
  input  logic                           q_ready_i,
  output logic                           push_o,
  output logic [Axes-1:0][SumW-1:0]      sum_o
);

  localparam int unsigned ExtW = SumW - SampleW;

  sample_t                  win_q [Axes][WINDOW_LEN];
  logic [Axes-1:0][SumW-1:0] sum_q, sum_d;
  logic                     take;

  assign ready_o = q_ready_i;
  assign take    = valid_i && q_ready_i;
  assign push_o  = take;

  // Running sum: add the incoming sample, drop the one leaving the window.
  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      sum_d[a] = sum_q[a]
               + {{ExtW{sample_i[a][SampleW-1]}}, sample_i[a]}
               - {{ExtW{win_q[a][0][SampleW-1]}}, win_q[a][0]};
    end
  end

  assign sum_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int a = 0; a < Axes; a++) begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
          win_q[a][i] <= '0;
        end
      end
    end else if (take) begin
      sum_q <= sum_d;
      for (int a = 0; a < Axes; a++) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_q[a][i] <= win_q[a][i+1];
        end
        win_q[a][WINDOW_LEN-1] <= sample_i[a];
      end
    end
  end

endmodule

### src/smavg_queue.sv
module smavg_queue import smavg_pkg::*; #(
  parameter int unsigned Width = 120
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### src/smavg_back.sv
module smavg_back import smavg_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 10,
  parameter int unsigned SumW       = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      pop_o,
  input  logic [Axes-1:0][SumW-1:0] sum_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output axes_t                     mean_o
);

  // Exact reciprocal for magnitudes below 2**SumW.
  localparam int unsigned RecipShift = SumW + $clog2(WINDOW_LEN);
  localparam longint unsigned RecipFull =
      ((longint'(1) << RecipShift) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [RecipShift-1:0] Recip = RecipShift'(RecipFull);
  localparam int unsigned ProdW = SumW + RecipShift;

  logic                             v1_q, v2_q, v3_q;
  logic                             en1, en2, en3;
  logic [Axes-1:0]                  neg1_q, neg2_q;
  logic [Axes-1:0][SumW-1:0]        mag1_q, mag_d;
  logic [Axes-1:0][ProdW-1:0]       prod2_q, prod_d;
  axes_t                            mean_q, mean_d;

  assign en3   = !v3_q || ready_i;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign pop_o = valid_i && en1;

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      mag_d[a]  = sum_i[a][SumW-1] ? (~sum_i[a] + SumW'(1)) : sum_i[a];
      prod_d[a] = ProdW'(mag1_q[a]) * ProdW'(Recip);
      mean_d[a] = neg2_q[a] ? (~prod2_q[a][RecipShift +: SampleW] + SampleW'(1))
                            : prod2_q[a][RecipShift +: SampleW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mag1_q <= mag_d;
      for (int a = 0; a < Axes; a++) begin
        neg1_q[a] <= sum_i[a][SumW-1];
      end
    end
    if (en2) begin
      prod2_q <= prod_d;
      neg2_q  <= neg1_q;
    end
    if (en3) begin
      mean_q <= mean_d;
    end
  end

  assign valid_o = v3_q;
  assign mean_o  = mean_q;

endmodule
